FILE: src/hsg_pkg.sv
package hsg_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 3'd4;

    localparam logic signed [47:0] GAIN_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] GAIN_MIN = 48'sh8000_0000_0000;
    localparam logic [16:0] ONE_Q = 17'd65536;

    localparam logic [6:0] STEPS_VAR  = 7'd64;
    localparam logic [6:0] STEPS_MEAN = 7'd32;
    localparam logic [6:0] STEPS_WGT  = 7'd41;
    localparam logic [6:0] STEPS_LEAF = 7'd48;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [32:0] divisor;
        logic [6:0]  steps;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic               split_valid;
        logic [15:0]        split_feature;
        logic [7:0]         split_bin;
        logic signed [47:0] split_gain;
        logic signed [31:0] left_grad_sum;
        logic [31:0]        left_hess_sum;
        logic [23:0]        left_samples;
        logic signed [31:0] right_grad_sum;
        logic [31:0]        right_hess_sum;
        logic [23:0]        right_samples;
        logic signed [31:0] left_leaf;
        logic signed [31:0] right_leaf;
    } t_split;

    function automatic logic [31:0] sat32(input logic [32:0] v);
        logic [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: src/hsg_bin_if.sv
interface hsg_bin_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] bin_grad;
    logic [31:0]        bin_hess;
    logic [23:0]        bin_samples;
    logic signed [31:0] parent_grad;
    logic [31:0]        parent_hess;
    logic [23:0]        parent_samples;
    logic [15:0]        feature_id;
    logic               last_bin;

    modport source (
        output valid, bin_grad, bin_hess, bin_samples, parent_grad, parent_hess,
               parent_samples, feature_id, last_bin,
        input  ready
    );
    modport sink (
        input  valid, bin_grad, bin_hess, bin_samples, parent_grad, parent_hess,
               parent_samples, feature_id, last_bin,
        output ready
    );
endinterface

FILE: src/hsg_split_if.sv
interface hsg_split_if;
    logic               valid;
    logic               ready;
    logic               split_valid;
    logic [15:0]        split_feature;
    logic [7:0]         split_bin;
    logic signed [47:0] split_gain;
    logic signed [31:0] left_grad_sum;
    logic [31:0]        left_hess_sum;
    logic [23:0]        left_samples;
    logic signed [31:0] right_grad_sum;
    logic [31:0]        right_hess_sum;
    logic [23:0]        right_samples;
    logic signed [31:0] left_leaf;
    logic signed [31:0] right_leaf;

    modport source (
        output valid, split_valid, split_feature, split_bin, split_gain, left_grad_sum,
               left_hess_sum, left_samples, right_grad_sum, right_hess_sum,
               right_samples, left_leaf, right_leaf,
        input  ready
    );
    modport sink (
        input  valid, split_valid, split_feature, split_bin, split_gain, left_grad_sum,
               left_hess_sum, left_samples, right_grad_sum, right_hess_sum,
               right_samples, left_leaf, right_leaf,
        output ready
    );
endinterface

FILE: src/hsg_div.sv
module hsg_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hsg_pkg::t_div_req i_req,
    output hsg_pkg::t_div_rsp o_rsp
);

    logic [63:0] r_q;
    logic [32:0] r_rem;
    logic [32:0] r_d;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [33:0] w_trial;
    logic        w_ge;

    assign w_trial = {r_rem, r_q[63]};
    assign w_ge = (w_trial >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_q    <= i_req.dividend;
                r_rem  <= '0;
                r_d    <= i_req.divisor;
                r_cnt  <= i_req.steps;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? 33'(w_trial - {1'b0, r_d}) : w_trial[32:0];
                r_q   <= {r_q[62:0], w_ge};
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

FILE: src/histogram_split_gain_scan.sv
// A bin that is not a split candidate returns to idle after the check; a variance
// candidate three divisions, a Gini candidate three 32-step and one 41-step division.
// A last bin runs two 48-step leaf divisions if a split was found, then transfers out.
// Throughput is set by the shared divider, which retires one quotient bit per cycle.
// Synchronous active-low reset restores the register defaults and clears the scan.
module histogram_split_gain_scan #(
    parameter int BIN_LIMIT = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [hsg_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [hsg_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    hsg_bin_if.sink                              i_bin,
    hsg_split_if.source                          o_split
);

    localparam int CAP_I = ((BIN_LIMIT - 1) < 255) ? (BIN_LIMIT - 1) : 255;
    localparam logic [7:0] POS_CAP = 8'(CAP_I);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CHK   = 5'd1;
    localparam logic [4:0] S_VMUL  = 5'd2;
    localparam logic [4:0] S_VDIV  = 5'd3;
    localparam logic [4:0] S_VWAIT = 5'd4;
    localparam logic [4:0] S_VGAIN = 5'd5;
    localparam logic [4:0] S_GDIV  = 5'd6;
    localparam logic [4:0] S_GWAIT = 5'd7;
    localparam logic [4:0] S_GMUL  = 5'd8;
    localparam logic [4:0] S_GSTO  = 5'd9;
    localparam logic [4:0] S_WM0   = 5'd10;
    localparam logic [4:0] S_WM1   = 5'd11;
    localparam logic [4:0] S_WDIV  = 5'd12;
    localparam logic [4:0] S_WWAIT = 5'd13;
    localparam logic [4:0] S_CMP   = 5'd14;
    localparam logic [4:0] S_ECHK  = 5'd15;
    localparam logic [4:0] S_LDIV  = 5'd16;
    localparam logic [4:0] S_LWAIT = 5'd17;
    localparam logic [4:0] S_EMIT  = 5'd18;

    logic [4:0]         r_state;
    logic [31:0]        r_lambda;
    logic [23:0]        r_min_cnt;
    logic [31:0]        r_min_wt;
    logic signed [47:0] r_min_gain;
    logic               r_mode;

    logic signed [31:0] r_pfx_g;
    logic [31:0]        r_pfx_h;
    logic [23:0]        r_pfx_n;
    logic [7:0]         r_pos;
    logic               r_best_found;
    logic signed [47:0] r_best_gain;
    logic [7:0]         r_best_bin;
    logic signed [31:0] r_best_lg;
    logic [31:0]        r_best_lh;
    logic [23:0]        r_best_ln;

    logic signed [31:0] r_pg;
    logic [31:0]        r_ph;
    logic [23:0]        r_pc;
    logic [15:0]        r_fid;
    logic               r_is_last;
    logic [7:0]         r_cand_bin;

    logic [1:0]         r_k;
    logic signed [31:0] r_rg;
    logic [31:0]        r_rh;
    logic [23:0]        r_rc;
    logic [63:0]        r_prod;
    logic [46:0]        r_vt [3];
    logic [16:0]        r_p;
    logic [15:0]        r_gini [3];
    logic [40:0]        r_wsum;
    logic signed [47:0] r_gain;
    logic signed [31:0] r_leaf [2];

    hsg_pkg::t_split    r_out;
    logic               r_out_vld;

    hsg_pkg::t_div_req  w_dreq;
    hsg_pkg::t_div_rsp  w_drsp;

    logic               w_acc;
    logic               w_out_free;
    logic signed [31:0] w_g;
    logic [31:0]        w_h;
    logic [23:0]        w_n;
    logic [31:0]        w_gmag;
    logic [32:0]        w_d;
    logic [24:0]        w_nt;
    logic signed [31:0] w_sub_g;
    logic [31:0]        w_sub_h;
    logic [23:0]        w_sub_n;
    logic [31:0]        w_rg_c;
    logic [32:0]        w_rh_c;
    logic [24:0]        w_rc_c;
    logic               w_cand;
    logic [32:0]        w_sum_g;
    logic [32:0]        w_sum_h;
    logic [24:0]        w_sum_n;
    logic signed [48:0] w_vsum;
    logic signed [33:0] w_m;
    logic signed [33:0] w_t;
    logic [16:0]        w_p;
    logic [47:0]        w_lq;
    logic [31:0]        w_leaf;

    assign w_acc = i_bin.valid && i_bin.ready;
    assign i_bin.ready = (r_state == S_IDLE);
    assign w_out_free = !r_out_vld || o_split.ready;

    always_comb begin
        unique case (r_k)
            2'd0: begin
                w_g = r_is_last ? r_best_lg : r_pfx_g;
                w_h = r_is_last ? r_best_lh : r_pfx_h;
                w_n = r_pfx_n;
            end
            2'd1: begin
                w_g = r_rg;
                w_h = r_rh;
                w_n = r_rc;
            end
            default: begin
                w_g = r_pg;
                w_h = r_ph;
                w_n = r_pc;
            end
        endcase
    end

    assign w_gmag = w_g[31] ? (~w_g + 32'd1) : w_g;
    assign w_d = {1'b0, w_h} + {1'b0, r_lambda};
    assign w_nt = {1'b0, r_pfx_n} + {1'b0, r_rc};

    assign w_sub_g = r_is_last ? r_best_lg : r_pfx_g;
    assign w_sub_h = r_is_last ? r_best_lh : r_pfx_h;
    assign w_sub_n = r_is_last ? r_best_ln : r_pfx_n;
    assign w_rg_c = hsg_pkg::sat32({r_pg[31], r_pg} - {w_sub_g[31], w_sub_g});
    assign w_rh_c = {1'b0, r_ph} - {1'b0, w_sub_h};
    assign w_rc_c = {1'b0, r_pc} - {1'b0, w_sub_n};
    assign w_cand = (r_pos < POS_CAP) && (r_pfx_n >= r_min_cnt) && (r_pfx_h >= r_min_wt)
                    && !w_rh_c[32] && !w_rc_c[24]
                    && (w_rc_c[23:0] >= r_min_cnt) && (w_rh_c[31:0] >= r_min_wt);

    assign w_sum_g = {r_pfx_g[31], r_pfx_g} + {i_bin.bin_grad[31], i_bin.bin_grad};
    assign w_sum_h = {1'b0, r_pfx_h} + {1'b0, i_bin.bin_hess};
    assign w_sum_n = {1'b0, r_pfx_n} + {1'b0, i_bin.bin_samples};

    assign w_vsum = $signed({2'b00, r_vt[0]}) + $signed({2'b00, r_vt[1]})
                    - $signed({2'b00, r_vt[2]});

    assign w_m = w_g[31] ? -$signed({2'b00, w_drsp.quot[31:0]})
                         : $signed({2'b00, w_drsp.quot[31:0]});
    assign w_t = w_m + $signed({17'd0, hsg_pkg::ONE_Q});
    always_comb begin
        if (w_t < 0) begin
            w_p = '0;
        end else if (w_t > $signed({16'd0, hsg_pkg::ONE_Q, 1'b0})) begin
            w_p = hsg_pkg::ONE_Q;
        end else begin
            w_p = w_t[17:1];
        end
    end

    assign w_lq = w_drsp.quot[47:0];
    always_comb begin
        if (w_g[31]) begin
            w_leaf = (w_lq > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : w_lq[31:0];
        end else begin
            w_leaf = (w_lq > 48'h8000_0000) ? 32'h8000_0000 : (~w_lq[31:0] + 32'd1);
        end
    end

    always_comb begin
        w_dreq.start    = 1'b0;
        w_dreq.dividend = r_prod;
        w_dreq.divisor  = w_d;
        w_dreq.steps    = hsg_pkg::STEPS_VAR;
        unique case (r_state)
            S_VDIV: begin
                w_dreq.start = (w_d != 33'd0);
            end
            S_GDIV: begin
                w_dreq.start    = (w_n != 24'd0);
                w_dreq.dividend = {w_gmag, 32'd0};
                w_dreq.divisor  = {9'd0, w_n};
                w_dreq.steps    = hsg_pkg::STEPS_MEAN;
            end
            S_WDIV: begin
                w_dreq.start    = (w_nt != 25'd0);
                w_dreq.dividend = {r_wsum, 23'd0};
                w_dreq.divisor  = {8'd0, w_nt};
                w_dreq.steps    = hsg_pkg::STEPS_WGT;
            end
            S_LDIV: begin
                w_dreq.start    = (w_d != 33'd0);
                w_dreq.dividend = {w_gmag, 32'd0};
                w_dreq.steps    = hsg_pkg::STEPS_LEAF;
            end
            default: begin
                w_dreq.start = 1'b0;
            end
        endcase
    end

    hsg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_lambda     <= 32'd65536;
            r_min_cnt    <= 24'd1;
            r_min_wt     <= '0;
            r_min_gain   <= '0;
            r_mode       <= 1'b0;
            r_pfx_g      <= '0;
            r_pfx_h      <= '0;
            r_pfx_n      <= '0;
            r_pos        <= '0;
            r_best_found <= 1'b0;
            r_best_gain  <= hsg_pkg::GAIN_MIN;
            r_best_bin   <= '0;
            r_best_lg    <= '0;
            r_best_lh    <= '0;
            r_best_ln    <= '0;
            r_is_last    <= 1'b0;
            r_k          <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    hsg_pkg::CFG_LAMBDA:  r_lambda   <= i_cfg_data[31:0];
                    hsg_pkg::CFG_MIN_CNT: r_min_cnt  <= i_cfg_data[23:0];
                    hsg_pkg::CFG_MIN_WT:  r_min_wt   <= i_cfg_data[31:0];
                    hsg_pkg::CFG_MIN_GN:  r_min_gain <= $signed(i_cfg_data[47:0]);
                    hsg_pkg::CFG_MODE:    r_mode     <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (o_split.ready && (r_state != S_EMIT)) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_pg      <= i_bin.parent_grad;
                        r_ph      <= i_bin.parent_hess;
                        r_pc      <= i_bin.parent_samples;
                        r_fid     <= i_bin.feature_id;
                        r_is_last <= i_bin.last_bin;
                        if (i_bin.last_bin) begin
                            r_state <= S_ECHK;
                        end else begin
                            r_pfx_g <= hsg_pkg::sat32(w_sum_g);
                            r_pfx_h <= w_sum_h[32] ? 32'hFFFF_FFFF : w_sum_h[31:0];
                            r_pfx_n <= w_sum_n[24] ? 24'hFF_FFFF : w_sum_n[23:0];
                            r_state <= S_CHK;
                        end
                    end
                end
                S_CHK: begin
                    r_cand_bin <= r_pos;
                    if (r_pos < POS_CAP) begin
                        r_pos <= r_pos + 8'd1;
                    end
                    r_rg <= w_rg_c;
                    r_rh <= w_rh_c[31:0];
                    r_rc <= w_rc_c[23:0];
                    r_k  <= 2'd0;
                    if (!w_cand) begin
                        r_state <= S_IDLE;
                    end else if (r_mode) begin
                        r_state <= S_GDIV;
                    end else begin
                        r_state <= S_VMUL;
                    end
                end
                S_VMUL: begin
                    r_prod  <= w_gmag * w_gmag;
                    r_state <= S_VDIV;
                end
                S_VDIV: begin
                    if (w_d == 33'd0) begin
                        r_vt[r_k] <= '0;
                        if (r_k == 2'd2) begin
                            r_state <= S_VGAIN;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= S_VMUL;
                        end
                    end else begin
                        r_state <= S_VWAIT;
                    end
                end
                S_VWAIT: begin
                    if (w_drsp.done) begin
                        r_vt[r_k] <= (w_drsp.quot > 64'(hsg_pkg::GAIN_MAX))
                                     ? hsg_pkg::GAIN_MAX[46:0] : w_drsp.quot[46:0];
                        if (r_k == 2'd2) begin
                            r_state <= S_VGAIN;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= S_VMUL;
                        end
                    end
                end
                S_VGAIN: begin
                    r_gain  <= 48'((w_vsum + (w_vsum[48] ? 49'sd1 : 49'sd0)) >>> 1);
                    r_state <= S_CMP;
                end
                S_GDIV: begin
                    if (w_n == 24'd0) begin
                        r_gini[r_k] <= '0;
                        if (r_k == 2'd2) begin
                            r_state <= S_WM0;
                        end else begin
                            r_k <= r_k + 2'd1;
                        end
                    end else begin
                        r_state <= S_GWAIT;
                    end
                end
                S_GWAIT: begin
                    if (w_drsp.done) begin
                        r_p     <= w_p;
                        r_state <= S_GMUL;
                    end
                end
                S_GMUL: begin
                    r_prod  <= 64'(r_p * (hsg_pkg::ONE_Q - r_p));
                    r_state <= S_GSTO;
                end
                S_GSTO: begin
                    r_gini[r_k] <= r_prod[30:15];
                    if (r_k == 2'd2) begin
                        r_state <= S_WM0;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_GDIV;
                    end
                end
                S_WM0: begin
                    r_prod  <= 64'(r_pfx_n * r_gini[0]);
                    r_state <= S_WM1;
                end
                S_WM1: begin
                    r_wsum  <= {1'b0, r_prod[39:0]} + 41'(r_rc * r_gini[1]);
                    r_state <= S_WDIV;
                end
                S_WDIV: begin
                    if (w_nt == 25'd0) begin
                        r_gain  <= '0;
                        r_state <= S_CMP;
                    end else begin
                        r_state <= S_WWAIT;
                    end
                end
                S_WWAIT: begin
                    if (w_drsp.done) begin
                        r_gain  <= $signed({32'd0, r_gini[2]}) - $signed(w_drsp.quot[47:0]);
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if ((r_gain > r_best_gain) && (r_gain >= r_min_gain)) begin
                        r_best_found <= 1'b1;
                        r_best_gain  <= r_gain;
                        r_best_bin   <= r_cand_bin;
                        r_best_lg    <= r_pfx_g;
                        r_best_lh    <= r_pfx_h;
                        r_best_ln    <= r_pfx_n;
                    end
                    r_state <= S_IDLE;
                end
                S_ECHK: begin
                    r_rg <= w_rg_c;
                    r_rh <= w_rh_c[32] ? 32'd0 : w_rh_c[31:0];
                    r_rc <= w_rc_c[24] ? 24'd0 : w_rc_c[23:0];
                    r_k  <= 2'd0;
                    r_state <= r_best_found ? S_LDIV : S_EMIT;
                end
                S_LDIV: begin
                    if (w_d == 33'd0) begin
                        r_leaf[r_k[0]] <= '0;
                        if (r_k == 2'd1) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_k <= r_k + 2'd1;
                        end
                    end else begin
                        r_state <= S_LWAIT;
                    end
                end
                S_LWAIT: begin
                    if (w_drsp.done) begin
                        r_leaf[r_k[0]] <= w_leaf;
                        if (r_k == 2'd1) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= S_LDIV;
                        end
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_vld           <= 1'b1;
                        r_out.split_valid   <= r_best_found;
                        r_out.split_feature <= r_fid;
                        if (r_best_found) begin
                            r_out.split_bin      <= r_best_bin;
                            r_out.split_gain     <= r_best_gain;
                            r_out.left_grad_sum  <= r_best_lg;
                            r_out.left_hess_sum  <= r_best_lh;
                            r_out.left_samples   <= r_best_ln;
                            r_out.right_grad_sum <= r_rg;
                            r_out.right_hess_sum <= r_rh;
                            r_out.right_samples  <= r_rc;
                            r_out.left_leaf      <= r_leaf[0];
                            r_out.right_leaf     <= r_leaf[1];
                        end else begin
                            r_out.split_bin      <= '0;
                            r_out.split_gain     <= '0;
                            r_out.left_grad_sum  <= '0;
                            r_out.left_hess_sum  <= '0;
                            r_out.left_samples   <= '0;
                            r_out.right_grad_sum <= '0;
                            r_out.right_hess_sum <= '0;
                            r_out.right_samples  <= '0;
                            r_out.left_leaf      <= '0;
                            r_out.right_leaf     <= '0;
                        end
                        r_pfx_g      <= '0;
                        r_pfx_h      <= '0;
                        r_pfx_n      <= '0;
                        r_pos        <= '0;
                        r_best_found <= 1'b0;
                        r_best_gain  <= hsg_pkg::GAIN_MIN;
                        r_best_bin   <= '0;
                        r_best_lg    <= '0;
                        r_best_lh    <= '0;
                        r_best_ln    <= '0;
                        r_is_last    <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_split.valid          = r_out_vld;
    assign o_split.split_valid    = r_out.split_valid;
    assign o_split.split_feature  = r_out.split_feature;
    assign o_split.split_bin      = r_out.split_bin;
    assign o_split.split_gain     = r_out.split_gain;
    assign o_split.left_grad_sum  = r_out.left_grad_sum;
    assign o_split.left_hess_sum  = r_out.left_hess_sum;
    assign o_split.left_samples   = r_out.left_samples;
    assign o_split.right_grad_sum = r_out.right_grad_sum;
    assign o_split.right_hess_sum = r_out.right_hess_sum;
    assign o_split.right_samples  = r_out.right_samples;
    assign o_split.left_leaf      = r_out.left_leaf;
    assign o_split.right_leaf     = r_out.right_leaf;

    a_no_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_dreq.start)
        else $error("divider started while idle");

    a_pos_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_CAP)
        else $error("bin position beyond cap");

    a_best_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_best_found |-> (r_best_gain == hsg_pkg::GAIN_MIN))
        else $error("best gain set without a best split");

    a_emit_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_out_free) |=> (!r_best_found && r_pos == 8'd0 && r_out_vld))
        else $error("scan state not cleared on transfer");

endmodule
